// ===== hw/rtl/eolf_pkg.sv =====
// Shared types and constants for the overwriting log FIFO.
// No dependencies; used by the FIFO and the encoder by scoped names.
`default_nettype none

package eolf_pkg;

    localparam int BUF_DEPTH = 4096;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int HELD_W    = $clog2(BUF_DEPTH + 1);
    localparam int LEVEL_W   = 13;

    // Operation codes.
    localparam logic [2:0] OP_PUT_RAW  = 3'd0;
    localparam logic [2:0] OP_PUT_BIN  = 3'd1;
    localparam logic [2:0] OP_PUT_CP   = 3'd2;
    localparam logic [2:0] OP_ADD_SKIP = 3'd3;
    localparam logic [2:0] OP_DRAIN    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEXT_LOG  = 2'd0;
    localparam logic [1:0] CFG_ENCODING  = 2'd1;
    localparam logic [1:0] CFG_TS_ENABLE = 2'd2;

    // Code point encodings.
    localparam logic [1:0] ENC_UTF8    = 2'd0;
    localparam logic [1:0] ENC_UTF16LE = 2'd1;
    localparam logic [1:0] ENC_UTF16BE = 2'd2;

    localparam logic [20:0] CP_NEWLINE = 21'h00000a;
    localparam logic [15:0] SKIP_MAX   = 16'hffff;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  data_byte;
        logic [20:0] code_point;
        logic [15:0] skip_amount;
        logic        paused;
        logic        suppressed;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               out_valid;
        logic               timestamp_due;
        logic [LEVEL_W-1:0] level;
    } t_out_item;

    // Encoded bytes of one code point; bytes[0] is stored first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } t_enc_bytes;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/encoding_overwrite_log_fifo.sv =====
// Overwriting log FIFO: a drain, a skip or a dropped put goes from idle straight to
// the result state; a byte put or a code point first writes its bytes to the store.
// One item is in flight at a time, the single-port store taking one byte write per
// cycle while the bytes of a put are written.
// Results are held in registers until taken. Synchronous active-low reset clears
// indices, counts and configuration; the store itself is not cleared.
`default_nettype none

module encoding_overwrite_log_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire eolf_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output eolf_pkg::t_out_item       o_out_item,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [1:0]           i_cfg_data
);

    localparam int AW = eolf_pkg::ADDR_W;
    localparam int HW = eolf_pkg::HELD_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(eolf_pkg::BUF_DEPTH - 1);
    localparam logic [HW-1:0] FULL     = HW'(eolf_pkg::BUF_DEPTH);

    eolf_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_wr_idx, r_rd_idx;
    logic [HW-1:0] r_held;
    logic [15:0]   r_skip;
    logic          r_line_head;
    logic          r_text_log;
    logic [1:0]    r_encoding;
    logic          r_ts_enable;

    logic [3:0][7:0] r_bytes;
    logic [2:0]      r_nbytes;
    logic [1:0]      r_bidx;
    logic            r_out_ok;
    logic            r_ts;

    logic                 accept;
    logic                 blocked;
    logic                 drain_go;
    logic                 last_byte;
    logic [2:0]           c_nbytes;
    logic [16:0]          skip_sum;
    logic [AW-1:0]        wr_next;
    logic [AW-1:0]        rd_next;
    eolf_pkg::t_enc_bytes enc;

    logic          ram_en, ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;

    eolf_encoder u_encoder (
        .i_code_point (i_in_item.code_point),
        .i_encoding   (r_encoding),
        .o_enc        (enc)
    );

    eolf_ram #(
        .DEPTH (eolf_pkg::BUF_DEPTH),
        .WIDTH (8)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_bytes[r_bidx]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        accept    = i_in_valid && (r_state == eolf_pkg::ST_IDLE);
        blocked   = i_in_item.paused || i_in_item.suppressed;
        drain_go  = (i_in_item.operation == eolf_pkg::OP_DRAIN) && (r_held != '0);
        last_byte = ({1'b0, r_bidx} + 3'd1) == r_nbytes;
        skip_sum  = {1'b0, r_skip} + {1'b0, i_in_item.skip_amount};
        wr_next   = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + AW'(1);
        rd_next   = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + AW'(1);

        // Number of bytes this item puts into the store.
        c_nbytes = 3'd0;
        unique case (i_in_item.operation)
            eolf_pkg::OP_PUT_RAW: c_nbytes = r_text_log ? 3'd1 : 3'd0;
            eolf_pkg::OP_PUT_BIN: begin
                if (!blocked && (r_text_log || r_skip == '0)) begin
                    c_nbytes = 3'd1;
                end
            end
            eolf_pkg::OP_PUT_CP:  c_nbytes = r_text_log ? enc.count : 3'd0;
            default:              c_nbytes = 3'd0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            eolf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (c_nbytes != 3'd0) ? eolf_pkg::ST_WRITE : eolf_pkg::ST_RESULT;
                end
            end
            eolf_pkg::ST_WRITE: begin
                if (last_byte) begin
                    n_state = eolf_pkg::ST_RESULT;
                end
            end
            eolf_pkg::ST_RESULT: begin
                if (!i_out_stall) begin
                    n_state = eolf_pkg::ST_IDLE;
                end
            end
            default: n_state = eolf_pkg::ST_IDLE;
        endcase
    end

    // Outputs and store control.
    always_comb begin
        o_in_stall  = (r_state != eolf_pkg::ST_IDLE);
        o_out_valid = (r_state == eolf_pkg::ST_RESULT);
        o_cfg_ready = 1'b1;
        ram_we      = (r_state == eolf_pkg::ST_WRITE);
        ram_en      = ram_we || (accept && drain_go);
        ram_addr    = ram_we ? r_wr_idx : r_rd_idx;
    end

    // The store read register holds the drained byte until the result is taken.
    always_comb begin
        o_out_item.out_byte      = r_out_ok ? ram_rdata : 8'h00;
        o_out_item.out_valid     = r_out_ok;
        o_out_item.timestamp_due = r_ts;
        o_out_item.level         = eolf_pkg::LEVEL_W'(r_held);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= eolf_pkg::ST_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_held      <= '0;
            r_skip      <= '0;
            r_line_head <= 1'b1;
            r_text_log  <= 1'b1;
            r_encoding  <= eolf_pkg::ENC_UTF8;
            r_ts_enable <= 1'b0;
            r_out_ok    <= 1'b0;
            r_ts        <= 1'b0;
            r_bidx      <= '0;
            r_nbytes    <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    eolf_pkg::CFG_TEXT_LOG:  r_text_log  <= i_cfg_data[0];
                    eolf_pkg::CFG_ENCODING:  r_encoding  <= i_cfg_data;
                    eolf_pkg::CFG_TS_ENABLE: r_ts_enable <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (accept) begin
                r_out_ok <= 1'b0;
                r_ts     <= 1'b0;
                r_bidx   <= '0;
                r_nbytes <= c_nbytes;
                unique case (i_in_item.operation)
                    eolf_pkg::OP_PUT_BIN: begin
                        if (!blocked && !r_text_log && r_skip != '0) begin
                            r_skip <= r_skip - 16'd1;
                        end
                    end
                    eolf_pkg::OP_PUT_CP: begin
                        if (r_text_log) begin
                            r_ts <= r_ts_enable && r_line_head;
                            if (i_in_item.code_point == eolf_pkg::CP_NEWLINE) begin
                                r_line_head <= 1'b1;
                            end else if (r_ts_enable) begin
                                r_line_head <= 1'b0;
                            end
                        end
                    end
                    eolf_pkg::OP_ADD_SKIP: begin
                        if (!r_text_log) begin
                            r_skip <= skip_sum[16] ? eolf_pkg::SKIP_MAX : skip_sum[15:0];
                        end
                    end
                    eolf_pkg::OP_DRAIN: begin
                        if (drain_go) begin
                            r_rd_idx <= rd_next;
                            r_held   <= r_held - HW'(1);
                            r_out_ok <= !blocked;
                        end
                    end
                    default: ;
                endcase
            end

            // One byte into the store per cycle; a full buffer drops its oldest byte.
            if (r_state == eolf_pkg::ST_WRITE) begin
                r_bidx   <= r_bidx + 2'd1;
                r_wr_idx <= wr_next;
                if (r_held == FULL) begin
                    r_rd_idx <= wr_next;
                end else begin
                    r_held <= r_held + HW'(1);
                end
            end
        end
    end

    // Byte payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_in_item.operation == eolf_pkg::OP_PUT_CP) begin
                r_bytes <= enc.bytes;
            end else begin
                r_bytes <= {24'h000000, i_in_item.data_byte};
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/eolf_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module eolf_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/eolf_encoder.sv =====
// Code point encoder: UTF-8, UTF-16LE or UTF-16BE into up to four bytes.
// Depends on eolf_pkg.
`default_nettype none

module eolf_encoder (
    input  wire logic [20:0]               i_code_point,
    input  wire logic [1:0]                i_encoding,
    output eolf_pkg::t_enc_bytes           o_enc
);

    logic [19:0] v;
    logic [15:0] unit_hi;
    logic [15:0] unit_lo;
    logic        in_bmp;
    logic        in_range;

    always_comb begin
        v        = 20'(i_code_point - 21'h010000);
        in_bmp   = (i_code_point < 21'h010000);
        in_range = (i_code_point < 21'h110000);
        // For supplementary planes the pair is high then low surrogate.
        unit_hi  = in_bmp ? i_code_point[15:0] : {6'b110110, v[19:10]};
        unit_lo  = {6'b110111, v[9:0]};

        o_enc.bytes = '0;
        o_enc.count = 3'd0;
        unique case (i_encoding)
            eolf_pkg::ENC_UTF8: begin
                if (i_code_point < 21'h000080) begin
                    o_enc.bytes[0] = {1'b0, i_code_point[6:0]};
                    o_enc.count    = 3'd1;
                end else if (i_code_point < 21'h000800) begin
                    o_enc.bytes[0] = {3'b110, i_code_point[10:6]};
                    o_enc.bytes[1] = {2'b10, i_code_point[5:0]};
                    o_enc.count    = 3'd2;
                end else if (in_bmp) begin
                    o_enc.bytes[0] = {4'b1110, i_code_point[15:12]};
                    o_enc.bytes[1] = {2'b10, i_code_point[11:6]};
                    o_enc.bytes[2] = {2'b10, i_code_point[5:0]};
                    o_enc.count    = 3'd3;
                end else if (in_range) begin
                    o_enc.bytes[0] = {5'b11110, i_code_point[20:18]};
                    o_enc.bytes[1] = {2'b10, i_code_point[17:12]};
                    o_enc.bytes[2] = {2'b10, i_code_point[11:6]};
                    o_enc.bytes[3] = {2'b10, i_code_point[5:0]};
                    o_enc.count    = 3'd4;
                end
            end
            eolf_pkg::ENC_UTF16LE: begin
                o_enc.bytes[0] = unit_hi[7:0];
                o_enc.bytes[1] = unit_hi[15:8];
                o_enc.bytes[2] = unit_lo[7:0];
                o_enc.bytes[3] = unit_lo[15:8];
                o_enc.count    = in_bmp ? 3'd2 : (in_range ? 3'd4 : 3'd0);
            end
            eolf_pkg::ENC_UTF16BE: begin
                o_enc.bytes[0] = unit_hi[15:8];
                o_enc.bytes[1] = unit_hi[7:0];
                o_enc.bytes[2] = unit_lo[15:8];
                o_enc.bytes[3] = unit_lo[7:0];
                o_enc.count    = in_bmp ? 3'd2 : (in_range ? 3'd4 : 3'd0);
            end
            default: begin
                o_enc.count = 3'd0;
            end
        endcase
    end

endmodule

`default_nettype wire
